FILE: rtl/mu8_pkg.sv
// ----------------------------------------------------------------------------
// mu8_pkg
// Shared types and constants for the modified UTF-8 string decoder.
// ----------------------------------------------------------------------------
package mu8_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;

    localparam logic [UNIT_W-1:0] UNIT_REPLACE = 16'h003F;  // '?'
    localparam logic [UNIT_W-1:0] UNIT_END     = 16'h0000;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_LEAD   = 3'b010,
        PH_CONT   = 3'b100
    } t_phase;

    // One buffered input beat handed from the input stage to the core.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_beat;

endpackage

FILE: rtl/mu8_in_stage.sv
// ----------------------------------------------------------------------------
// mu8_in_stage
// Input register: holds one accepted byte until the core takes it.
// ----------------------------------------------------------------------------
module mu8_in_stage
    import mu8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_take,
    output t_in_beat          o_beat
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_data;

    assign o_s_tready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_s_tvalid && o_s_tready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_data <= i_s_tdata;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

FILE: rtl/mu8_core.sv
// ----------------------------------------------------------------------------
// mu8_core
// Decode state, one-byte state update and result register.
// ----------------------------------------------------------------------------
module mu8_core
    import mu8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_beat          i_beat,
    output logic              o_take,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [UNIT_W-1:0] o_m_tdata,
    output logic              o_m_tlast
);

    t_phase            r_phase,   n_phase;
    logic [1:0]        r_pending, n_pending;
    logic [UNIT_W-1:0] r_partial, n_partial;
    logic              r_replace, n_replace;
    logic              r_out_valid, n_out_valid;
    logic [UNIT_W-1:0] r_out_unit;
    logic              r_out_last;

    logic              lead;
    logic              emit;
    logic [UNIT_W-1:0] unit;
    logic              eos;
    logic [BYTE_W-1:0] b;

    assign b      = i_beat.data;
    assign o_take = i_beat.valid && (!r_out_valid || i_m_tready);

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_partial = r_partial;
        n_replace = r_replace;
        lead      = 1'b0;
        emit      = 1'b0;
        unit      = UNIT_END;
        eos       = 1'b0;

        case (r_phase)
            PH_LEAD: begin
                lead = 1'b1;
            end
            PH_CONT: begin
                if (r_pending == 2'd0) begin
                    lead = 1'b1;
                end else begin
                    n_pending = r_pending - 2'd1;
                    if (!r_replace) begin
                        if (n_pending == 2'd1) begin
                            n_partial = r_partial | {4'b0, b[5:0], 6'b0};
                        end else begin
                            n_partial = r_partial | {10'b0, b[5:0]};
                        end
                    end
                    if (n_pending == 2'd0) begin
                        n_phase = PH_LEAD;
                        emit    = 1'b1;
                        if (r_replace) begin
                            n_replace = 1'b0;
                            unit      = UNIT_REPLACE;
                        end else begin
                            unit = n_partial;
                        end
                    end
                end
            end
            default: begin
                // length prefix: skip until a byte with the top bit clear
                n_phase = b[7] ? PH_PREFIX : PH_LEAD;
            end
        endcase

        if (lead) begin
            if (b == 8'h00) begin
                n_phase = PH_PREFIX;
                emit    = 1'b1;
                unit    = UNIT_END;
                eos     = 1'b1;
            end else if (!b[7]) begin
                n_phase = PH_LEAD;
                emit    = 1'b1;
                unit    = {8'b0, b};
            end else begin
                n_phase = PH_CONT;
                if (b[7:5] == 3'b110) begin
                    n_partial = {5'b0, b[4:0], 6'b0};
                    n_pending = 2'd1;
                    n_replace = 1'b0;
                end else if (b[7:4] == 4'b1110) begin
                    n_partial = {b[3:0], 12'b0};
                    n_pending = 2'd2;
                    n_replace = 1'b0;
                end else begin
                    n_partial = '0;
                    n_pending = 2'd3;
                    n_replace = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take && emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_pending   <= 2'd0;
            r_partial   <= '0;
            r_replace   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_partial <= n_partial;
                r_replace <= n_replace;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out_unit <= unit;
            r_out_last <= eos;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_unit;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: rtl/mutf8_string_decoder.sv
// ----------------------------------------------------------------------------
// mutf8_string_decoder
// Modified UTF-8 string decoder: strips the length prefix of each string item
// and emits full 16-bit code units, with tlast on the terminating zero.
// ----------------------------------------------------------------------------
// Path: the byte that completes a code unit is held in the input register,
//   then its result is written to the result register and leaves from there.
// Throughput: one byte per cycle while the result register is free or drains,
//   set by the state update in the core; prefix bytes, multi-byte and
//   unsupported leads and non-final continuation bytes emit nothing.
// Reset: synchronous, active low; clears the decode state to the length
//   prefix phase and empties both the input and the result register.
// ----------------------------------------------------------------------------
module mutf8_string_decoder
    import mu8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] data_byte
    // master side
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [UNIT_W-1:0] o_m_tdata,   // [15:0] code_unit
    output logic              o_m_tlast    // end_of_string
);

    t_in_beat in_beat;
    logic     take;

    // Hold one input beat so a byte can be taken while a result is stalled.
    mu8_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_take     (take),
        .o_beat     (in_beat)
    );

    // Advance the decode state on each taken beat and register the result.
    // The core takes a beat whenever its result register is free or drains
    // in the same cycle, so a steady stream moves one byte per cycle.
    mu8_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (in_beat),
        .o_take     (take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // The end marker always carries a zero code unit.
    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == UNIT_END))
        else $error("end-of-string beat with nonzero code unit");

    // Input backpressure only arises from a held byte behind a stalled result.
    a_ready_low_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (in_beat.valid && o_m_tvalid && !i_m_tready))
        else $error("input stalled without a stalled result");

    // Nothing is presented in the cycle after a reset edge.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("pipeline not empty after reset");
`endif

endmodule

FILE: tb/sv/tb_mutf8_string_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mutf8_string_decoder
// Self-checking bench for the modified UTF-8 string decoder. Drives a byte
// stream of length-prefixed strings, runs a byte-level decoder model in step
// with every accepted beat, and compares each output beat (code unit and
// tlast) against the oldest expected unit. Stalls on both sides are random, but for a final no-stall regime.
// ----------------------------------------------------------------------------
module tb_mutf8_string_decoder;
    import mu8_pkg::*;

    // One expected output beat: code unit plus the end-of-string flag.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } t_unit_beat;

    // Directed stimulus row. When typed is set, the expected beat is taken
    // from the row itself; otherwise the decoder model supplies it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic              has_unit;
        t_unit_beat        unit_due;
    } t_stim_row;

    localparam int NUM_ROWS   = 25;
    localparam int DRAIN_CYC  = 8;    // margin watched for stray beats after the drain

    logic              i_clk    = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [UNIT_W-1:0] m_tdata;
    logic              m_tlast;

    int tx_idle_pct = 14;
    int rx_idle_pct = 69;
    int beats_sent  = 0;
    int errors      = 0;

    t_unit_beat units_due[$];

    // Decoder model state
    t_phase            dec_phase   = PH_PREFIX;
    logic [1:0]        dec_pending = '0;
    logic [UNIT_W-1:0] dec_partial = '0;
    logic              dec_replace = 1'b0;

    // Directed walk: prefix skip, extremes of each form, encoded zero,
    // zero continuation, unsupported lead, terminator and an empty string.
    t_stim_row stim_rows [NUM_ROWS] = '{
        '{8'h80, 1'b1, 1'b0, '{16'h0000, 1'b0}},  // prefix, top bit set
        '{8'hFF, 1'b1, 1'b0, '{16'h0000, 1'b0}},
        '{8'h05, 1'b1, 1'b0, '{16'h0000, 1'b0}},  // last prefix byte
        '{8'h41, 1'b1, 1'b1, '{16'h0041, 1'b0}},
        '{8'h7F, 1'b1, 1'b1, '{16'h007F, 1'b0}},
        '{8'hC0, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b0}},  // encoded zero, no tlast
        '{8'hDF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{16'h07FF, 1'b0}},
        '{8'hEF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hBF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hBF, 1'b1, 1'b1, '{16'hFFFF, 1'b0}},
        '{8'hE0, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0}},  // zero consumed as data
        '{8'h00, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{8'hE4, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hB8, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hAD, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hF8, 1'b0, 1'b0, '{16'h0000, 1'b0}},  // unsupported lead
        '{8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{8'h80, 1'b1, 1'b1, '{UNIT_REPLACE, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{UNIT_END, 1'b1}},  // terminator
        '{8'h00, 1'b1, 1'b0, '{16'h0000, 1'b0}},  // one-byte prefix
        '{8'h00, 1'b1, 1'b1, '{UNIT_END, 1'b1}}   // empty string
    };

    mutf8_string_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] data_byte
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [15:0] code_unit
        .o_m_tlast  (m_tlast)    // end_of_string
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the decoder model by one accepted byte; return 1 when the byte
    // completes a unit, with that unit in u.
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b, output t_unit_beat u);
        u = '0;
        if (dec_phase == PH_CONT && dec_pending != 2'd0) begin
            dec_pending = dec_pending - 2'd1;
            // Swallowed forms keep no payload.
            if (!dec_replace)
                dec_partial = dec_partial | ({10'd0, b[5:0]} << (6 * dec_pending));
            if (dec_pending != 2'd0)
                return 1'b0;
            dec_phase = PH_LEAD;
            u.unit = dec_replace ? UNIT_REPLACE : dec_partial;
            dec_replace = 1'b0;
            return 1'b1;
        end
        if (dec_phase == PH_LEAD || dec_phase == PH_CONT) begin
            if (b == 8'h00) begin
                dec_phase = PH_PREFIX;
                u.unit = UNIT_END;
                u.last = 1'b1;
                return 1'b1;
            end
            if (!b[7]) begin
                dec_phase = PH_LEAD;
                u.unit = {8'h00, b};
                return 1'b1;
            end
            dec_phase = PH_CONT;
            if (b[7:5] == 3'b110) begin
                dec_partial = {5'd0, b[4:0], 6'd0};
                dec_pending = 2'd1;
                dec_replace = 1'b0;
            end else if (b[7:4] == 4'b1110) begin
                dec_partial = {b[3:0], 12'd0};
                dec_pending = 2'd2;
                dec_replace = 1'b0;
            end else begin
                dec_partial = '0;
                dec_pending = 2'd3;
                dec_replace = 1'b1;
            end
            return 1'b0;
        end
        // Length prefix: skip up to the first byte with the top bit clear.
        dec_phase = b[7] ? PH_PREFIX : PH_LEAD;
        return 1'b0;
    endfunction

    // Continuation byte: mostly well formed, sometimes any byte at all.
    function automatic logic [BYTE_W-1:0] rand_cont();
        if ($urandom_range(0, 3) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return 8'h80 | BYTE_W'($urandom_range(0, 63));
    endfunction

    // Drive one beat and hold it until the handshake completes. Returns at the
    // edge that accepted it. Optionally idle first, with junk on tdata.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= BYTE_W'($urandom_range(0, 255));
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    // Send one byte and queue whatever unit the model predicts for it.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_unit_beat u;
        send_byte(b);
        if (decode_byte(b, u))
            units_due = {units_due, u};
    endtask

    // One string item with random content, malformed forms included.
    task automatic send_string();
        int kind;
        repeat ($urandom_range(0, 3)) push_byte(8'h80 | BYTE_W'($urandom_range(0, 127)));
        push_byte(BYTE_W'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 10)) begin
            kind = int'($urandom_range(0, 9));
            if (kind < 4) begin
                push_byte(BYTE_W'($urandom_range(1, 127)));
            end else if (kind < 6) begin
                push_byte(8'hC0 | BYTE_W'($urandom_range(0, 31)));
                push_byte(rand_cont());
            end else if (kind < 8) begin
                push_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
                push_byte(rand_cont());
                push_byte(rand_cont());
            end else begin
                // Unsupported lead: stray continuation or four-byte and up.
                push_byte(kind == 8 ? BYTE_W'($urandom_range(8'h80, 8'hBF))
                                    : BYTE_W'($urandom_range(8'hF0, 8'hFF)));
                repeat (3) push_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        push_byte(8'h00);
    endtask

    // Receiver: drop tready at random per the current idle rate.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every accepted output beat against the oldest expected unit.
    always @(posedge i_clk) begin
        t_unit_beat due;
        if (rst_n && m_tvalid && m_tready) begin
            if (units_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual unit %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                due = units_due.pop_front();
                if (m_tdata !== due.unit) begin
                    errors++;
                    $display("%0t: code_unit mismatch, expected %h, actual %h",
                             $time, due.unit, m_tdata);
                end
                if (m_tlast !== due.last) begin
                    errors++;
                    $display("%0t: end_of_string mismatch, expected %b, actual %b",
                             $time, due.last, m_tlast);
                end
            end
        end
    end

    initial begin
        t_unit_beat u;
        logic       has;

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk: typed rows override the model but still advance it.
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_byte(stim_rows[i].data);
            has = decode_byte(stim_rows[i].data, u);
            if (stim_rows[i].typed) begin
                has = stim_rows[i].has_unit;
                u   = stim_rows[i].unit_due;
            end
            if (has)
                units_due = {units_due, u};
        end

        // Random strings with some raw noise mixed in, in three stall regimes.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 14; rx_idle_pct = 69; end
                1: begin tx_idle_pct = 69; rx_idle_pct = 14; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            while (beats_sent < NUM_ROWS + 370 * (ph + 1)) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom_range(0, 255)));
                else
                    send_string();
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray beats.
        while (units_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (errors == 0 && units_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
